>>> rtl/core/mfs_pkg.sv
// Shared types, constants and helper functions of the MicroDVD frame shift unit.
// No dependencies; all files but mfs_cmd_fifo refer to it by scoped names.
`timescale 1ns / 1ps

package mfs_pkg;

    // Default values of the top-level parameters
    localparam int VALUE_BITS_DEF     = 32;
    localparam int MAX_OUT_DIGITS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // Register fields
    localparam int DELAY_W = 27;
    localparam int RATE_W  = 10;
    localparam logic [RATE_W-1:0] RATE_RESET = 10'd25;

    // Frame shift = delay * rate / 1000. The divisor exceeds 2^9, so the
    // quotient needs nine bits less than the product.
    localparam int PROD_W    = DELAY_W + RATE_W;
    localparam int SHIFT_W   = PROD_W - 9;

    // Divide by 1000 as a shift by three (1000 = 8 * 125), then a multiply by
    // ceil(2^41 / 125) and a shift by 41; exact for any dividend below 2^34.
    localparam int                 DIV_PRE_SH = 3;
    localparam int                 QUO_IN_W   = PROD_W - DIV_PRE_SH;
    localparam int                 RECIP_W    = 35;
    localparam logic [RECIP_W-1:0] RECIP_125  = 35'd17592186045;
    localparam int                 RECIP_SH   = 41;

    // Register indexes, taken from paddr[2]
    localparam logic REG_DELAY_IDX = 1'b0;
    localparam logic REG_RATE_IDX  = 1'b1;

    // Characters
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Output pieces still owed for one command, in emission order
    typedef struct packed {
        logic pre;    // '{' of a brace that turned out not to open a field
        logic chr;    // the input byte itself
        logic post;   // '{' still pending at end of stream
        logic frm;    // a whole frame field: '{', digits, '}'
        logic nl;     // appended newline
    } pend_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        pend_t      pend;
    } cmd_head_t;

    localparam int CMD_HEAD_W = $bits(cmd_head_t);

    // Saturation limit: min(2^vb - 1, 10^md - 1), evaluated at elaboration
    function automatic logic [63:0] value_cap(input int vb, input int md);
        logic [63:0] bin;
        logic [63:0] dec;
        bin = (64'd1 << vb) - 64'd1;
        dec = 64'd1;
        for (int i = 0; i < md; i++) begin
            dec = dec * 64'd10;
        end
        dec = dec - 64'd1;
        return (bin < dec) ? bin : dec;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

>>> rtl/core/mfs_shift_calc.sv
// Frame shift calculator: one 27x10 multiply, then divide by 1000 as a shift by three
// and a reciprocal multiply for 125 in two half-width steps. Depends on mfs_pkg.
`timescale 1ns / 1ps

module mfs_shift_calc (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start_i,
    input  logic [mfs_pkg::DELAY_W-1:0] delay_i,
    input  logic [mfs_pkg::RATE_W-1:0]  rate_i,
    output logic [mfs_pkg::SHIFT_W-1:0] shift_o,
    output logic                        valid_o
);

    localparam int HALF_W = (mfs_pkg::QUO_IN_W + 1) / 2;
    localparam int PART_W = HALF_W + mfs_pkg::RECIP_W;
    localparam int ACC_W  = mfs_pkg::QUO_IN_W + mfs_pkg::RECIP_W;

    logic                          arm_reg;
    logic                          lo_reg;
    logic                          hi_reg;
    logic [mfs_pkg::QUO_IN_W-1:0]  quo_reg;
    logic [HALF_W-1:0]             half;
    logic [PART_W-1:0]             part;
    logic [ACC_W-1:0]              acc_reg;
    logic                          valid_reg;

    // low half of the dividend first, then the high half
    always_comb begin
        half = lo_reg ? quo_reg[HALF_W-1:0]
                      : HALF_W'(quo_reg[mfs_pkg::QUO_IN_W-1:HALF_W]);
        part = PART_W'(half) * PART_W'(mfs_pkg::RECIP_125);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_reg   <= 1'b0;
            lo_reg    <= 1'b0;
            hi_reg    <= 1'b0;
            quo_reg   <= '0;
            acc_reg   <= '0;
            valid_reg <= 1'b1;
        end else if (start_i) begin
            // registers take the new value at this edge; multiply next cycle
            arm_reg   <= 1'b1;
            lo_reg    <= 1'b0;
            hi_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end else if (arm_reg) begin
            arm_reg <= 1'b0;
            quo_reg <= mfs_pkg::QUO_IN_W'((mfs_pkg::PROD_W'(delay_i) *
                                           mfs_pkg::PROD_W'(rate_i)) >> mfs_pkg::DIV_PRE_SH);
            lo_reg  <= 1'b1;
        end else if (lo_reg) begin
            acc_reg <= ACC_W'(part);
            lo_reg  <= 1'b0;
            hi_reg  <= 1'b1;
        end else if (hi_reg) begin
            acc_reg   <= acc_reg + (ACC_W'(part) << HALF_W);
            hi_reg    <= 1'b0;
            valid_reg <= 1'b1;
        end
    end

    assign shift_o = acc_reg[mfs_pkg::RECIP_SH +: mfs_pkg::SHIFT_W];
    assign valid_o = valid_reg;

    a_valid_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> !lo_reg && !hi_reg && !arm_reg)
        else $error("shift flagged valid while the divide is still running");

endmodule

>>> rtl/core/mfs_front.sv
// Front end: accepts text bytes, tracks brace/field parsing and issues at most one
// output command per byte. Depends on mfs_pkg.
`timescale 1ns / 1ps

module mfs_front #(
    parameter int VALUE_BITS     = mfs_pkg::VALUE_BITS_DEF,
    parameter int MAX_OUT_DIGITS = mfs_pkg::MAX_OUT_DIGITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_char,
    input  logic                  s_in_last,
    input  logic                  full_i,
    output logic                  push_o,
    output mfs_pkg::cmd_head_t    head_o,
    output logic [VALUE_BITS-1:0] value_o
);

    localparam logic [VALUE_BITS-1:0] CAP =
        VALUE_BITS'(mfs_pkg::value_cap(VALUE_BITS, MAX_OUT_DIGITS));
    localparam int MW = VALUE_BITS + 4;

    typedef enum logic [2:0] {
        M_COPY  = 3'b001,
        M_BRACE = 3'b010,
        M_FRAME = 3'b100
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  done_reg, done_next;
    logic                  lwn_reg, lwn_next;
    mfs_pkg::pend_t        pend;
    logic                  is_dig;
    logic [MW-1:0]         mul10;
    logic [VALUE_BITS-1:0] mul_sat;
    logic                  any_emit;
    logic                  lwn_cur;
    logic                  accept;

    assign s_ready = !full_i;
    assign accept  = s_valid && s_ready;

    always_comb begin
        mode_next  = mode_reg;
        value_next = value_reg;
        done_next  = done_reg;
        pend       = '0;
        is_dig     = mfs_pkg::is_digit(s_in_char);
        mul10      = ({4'b0, value_reg} << 3) + ({4'b0, value_reg} << 1)
                   + MW'(s_in_char[3:0]);
        mul_sat    = (mul10 > MW'(CAP)) ? CAP : mul10[VALUE_BITS-1:0];

        case (mode_reg)
            M_BRACE: begin
                if (is_dig) begin
                    mode_next  = M_FRAME;
                    value_next = VALUE_BITS'(s_in_char[3:0]);
                    done_next  = 1'b0;
                end else begin
                    pend.pre = 1'b1;
                    if (s_in_char == mfs_pkg::CHAR_LBRACE) begin
                        mode_next = M_BRACE;
                    end else begin
                        pend.chr  = 1'b1;
                        mode_next = M_COPY;
                    end
                end
            end
            M_FRAME: begin
                if (s_in_char == mfs_pkg::CHAR_RBRACE) begin
                    pend.frm  = 1'b1;
                    mode_next = M_COPY;
                end else if (!done_reg && is_dig) begin
                    value_next = mul_sat;
                end else begin
                    done_next = 1'b1;
                end
            end
            default: begin
                if (s_in_char == mfs_pkg::CHAR_LBRACE) begin
                    mode_next = M_BRACE;
                end else begin
                    pend.chr = 1'b1;
                end
            end
        endcase

        // end of stream: flush a pending brace or an open field
        if (s_in_last) begin
            if (mode_next == M_BRACE) begin
                pend.post = 1'b1;
            end else if (mode_next == M_FRAME) begin
                pend.frm = 1'b1;
            end
        end

        any_emit = pend.pre || pend.chr || pend.post || pend.frm;
        lwn_cur  = any_emit ? (pend.chr && !pend.post && !pend.frm &&
                               (s_in_char == mfs_pkg::CHAR_LF))
                            : lwn_reg;
        pend.nl  = s_in_last && !lwn_cur;

        if (s_in_last) begin
            mode_next = M_COPY;
            lwn_next  = 1'b0;
        end else begin
            lwn_next  = lwn_cur;
        end
    end

    // value_reg is reloaded on every field entry, so it needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_COPY;
            done_reg <= 1'b0;
            lwn_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            done_reg <= done_next;
            lwn_reg  <= lwn_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            value_reg <= value_next;
        end
    end

    assign push_o      = accept && (pend != '0);
    assign head_o.ch   = s_in_char;
    assign head_o.last = s_in_last;
    assign head_o.pend = pend;
    assign value_o     = value_next;

endmodule

>>> rtl/core/mfs_cmd_fifo.sv
// Short command queue between front and back end, held in flip-flops.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module mfs_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_i,
    input  logic [WIDTH-1:0] wr_data_i,
    input  logic             pop_i,
    output logic [WIDTH-1:0] rd_data_o,
    output logic             not_empty_o,
    output logic             full_o
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_i) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop_i) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push_i && !pop_i) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop_i && !push_i) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wr_ptr_reg] <= wr_data_i;
        end
    end

    assign rd_data_o   = mem_reg[rd_ptr_reg];
    assign not_empty_o = count_reg != '0;
    assign full_o      = count_reg == CNT_W'(DEPTH);

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_i |-> count_reg != '0)
        else $error("command queue popped while empty");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_i && !pop_i) |-> count_reg != CNT_W'(DEPTH))
        else $error("command queue written while full");

endmodule

>>> rtl/core/mfs_back.sv
// Back end: expands queued commands into output bytes, with a shift-add-3
// binary to decimal converter for frame fields. Depends on mfs_pkg.
`timescale 1ns / 1ps

module mfs_back #(
    parameter int VALUE_BITS     = mfs_pkg::VALUE_BITS_DEF,
    parameter int MAX_OUT_DIGITS = mfs_pkg::MAX_OUT_DIGITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid_i,
    output logic                        pop_o,
    input  mfs_pkg::cmd_head_t          head_i,
    input  logic [VALUE_BITS-1:0]       value_i,
    input  logic [mfs_pkg::SHIFT_W-1:0] shift_i,
    input  logic                        shift_valid_i,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_char,
    output logic                        m_run_end,
    output logic                        m_stream_end
);

    localparam logic [VALUE_BITS-1:0] CAP =
        VALUE_BITS'(mfs_pkg::value_cap(VALUE_BITS, MAX_OUT_DIGITS));
    localparam int ADD_W = ((VALUE_BITS > mfs_pkg::SHIFT_W) ? VALUE_BITS
                                                            : mfs_pkg::SHIFT_W) + 1;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_W = $clog2(MAX_OUT_DIGITS);
    localparam int BCD_W = MAX_OUT_DIGITS * 4;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EMIT   = 6'b000010,
        S_CONV   = 6'b000100,
        S_OPEN   = 6'b001000,
        S_DIGITS = 6'b010000,
        S_CLOSE  = 6'b100000
    } state_t;

    state_t                              state_reg, state_next;
    mfs_pkg::cmd_head_t                  cmd_reg, cmd_next;
    logic [VALUE_BITS-1:0]               val_reg, val_next;
    logic [MAX_OUT_DIGITS-1:0][3:0]      bcd_reg, bcd_next, adj;
    logic [BCD_W-1:0]                    adj_flat;
    logic [VALUE_BITS-1:0]               bin_reg, bin_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic [DIG_W-1:0]                    dig_reg, dig_next, top_dig;
    logic [ADD_W-1:0]                    sum_full;
    logic [VALUE_BITS-1:0]               sum_sat;
    mfs_pkg::pend_t                      rest;
    logic                                out_free;
    logic                                emit, emit_last, fetch;
    logic [7:0]                          emit_char;
    logic                                m_valid_reg;
    logic [7:0]                          m_char_reg;
    logic                                m_run_end_reg, m_stream_end_reg;

    assign out_free = !m_valid_reg || m_ready;

    // saturating shifted value
    always_comb begin
        sum_full = ADD_W'(val_reg) + ADD_W'(shift_i);
        sum_sat  = (sum_full > ADD_W'(CAP)) ? CAP : sum_full[VALUE_BITS-1:0];
    end

    // add-3 per digit, and the most significant non-zero digit
    always_comb begin
        top_dig = '0;
        for (int i = 0; i < MAX_OUT_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
            if (bcd_reg[i] != 4'd0) begin
                top_dig = DIG_W'(i);
            end
        end
        adj_flat = adj;
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        val_next   = val_reg;
        bcd_next   = bcd_reg;
        bin_next   = bin_reg;
        cnt_next   = cnt_reg;
        dig_next   = dig_reg;
        rest       = cmd_reg.pend;
        emit       = 1'b0;
        emit_char  = mfs_pkg::CHAR_LF;
        emit_last  = 1'b0;
        fetch      = 1'b0;
        pop_o      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                fetch = 1'b1;
            end
            S_EMIT: begin
                if (cmd_reg.pend.frm && !cmd_reg.pend.pre && !cmd_reg.pend.chr &&
                    !cmd_reg.pend.post) begin
                    // field: wait for the shift, then start the conversion
                    if (shift_valid_i) begin
                        bcd_next   = '0;
                        bin_next   = sum_sat;
                        cnt_next   = CNT_W'(VALUE_BITS);
                        state_next = S_CONV;
                    end
                end else if (out_free) begin
                    emit = 1'b1;
                    if (cmd_reg.pend.pre) begin
                        emit_char = mfs_pkg::CHAR_LBRACE;
                        rest.pre  = 1'b0;
                    end else if (cmd_reg.pend.chr) begin
                        emit_char = cmd_reg.ch;
                        rest.chr  = 1'b0;
                    end else if (cmd_reg.pend.post) begin
                        emit_char = mfs_pkg::CHAR_LBRACE;
                        rest.post = 1'b0;
                    end else begin
                        emit_char = mfs_pkg::CHAR_LF;
                        rest.nl   = 1'b0;
                    end
                    cmd_next.pend = rest;
                    if (rest == '0) begin
                        emit_last = 1'b1;
                        fetch     = 1'b1;
                    end
                end
            end
            S_CONV: begin
                bcd_next = {adj_flat[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = S_OPEN;
                end
            end
            S_OPEN: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_char  = mfs_pkg::CHAR_LBRACE;
                    dig_next   = top_dig;
                    state_next = S_DIGITS;
                end
            end
            S_DIGITS: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = mfs_pkg::CHAR_ZERO + {4'b0, bcd_reg[dig_reg]};
                    if (dig_reg == '0) begin
                        state_next = S_CLOSE;
                    end else begin
                        dig_next = dig_reg - DIG_W'(1);
                    end
                end
            end
            S_CLOSE: begin
                if (out_free) begin
                    emit          = 1'b1;
                    emit_char     = mfs_pkg::CHAR_RBRACE;
                    rest.frm      = 1'b0;
                    cmd_next.pend = rest;
                    if (rest == '0) begin
                        emit_last = 1'b1;
                        fetch     = 1'b1;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // take the next command as soon as the current one is done
        if (fetch) begin
            if (cmd_valid_i) begin
                pop_o      = 1'b1;
                cmd_next   = head_i;
                val_next   = value_i;
                state_next = S_EMIT;
            end else begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        val_reg <= val_next;
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
        cnt_reg <= cnt_next;
        dig_reg <= dig_next;
        if (emit) begin
            m_char_reg       <= emit_char;
            m_run_end_reg    <= emit_last;
            m_stream_end_reg <= emit_last && cmd_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_char   = m_char_reg;
    assign m_run_end    = m_run_end_reg;
    assign m_stream_end = m_stream_end_reg;

    a_stream_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stream_end_reg) |-> m_run_end_reg)
        else $error("stream end flagged on a byte that does not end its run");

    a_conv_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OPEN) |-> (bin_reg == '0))
        else $error("decimal conversion left binary bits unshifted");

    a_conv_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CONV) |=> (state_reg == S_CONV) || (state_reg == S_OPEN))
        else $error("conversion left for a state other than field open");

endmodule

>>> rtl/core/microdvd_frame_shift_unit.sv
// MicroDVD frame shift unit: plain bytes go in and out at one transfer per cycle unless a field
// or output back-pressure holds the back end; each passes the command queue, the back end's
// command register and the output register. A queue of QUEUE_DEPTH commands decouples sides.
// A field waits for a valid shift, then converts to decimal (shift-add-3, one bit per cycle) and
// emits '{', digits, '}' and an optional newline. A register write recomputes the shift by one
// multiply and two reciprocal partial products. Synchronous active-low reset clears control.
`timescale 1ns / 1ps

module microdvd_frame_shift_unit #(
    parameter int VALUE_BITS     = mfs_pkg::VALUE_BITS_DEF,
    parameter int MAX_OUT_DIGITS = mfs_pkg::MAX_OUT_DIGITS_DEF,
    parameter int QUEUE_DEPTH    = mfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_char,
    input  logic        s_in_last,
    // output byte channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_run_end,
    output logic        m_stream_end,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FIFO_W = mfs_pkg::CMD_HEAD_W + VALUE_BITS;

    // ------------------------------------------------------------------
    // Registers: delay_ms at 0x0, frame_rate at 0x4. Writes complete in
    // the access phase; pready is tied high so there are no wait states.
    // ------------------------------------------------------------------
    logic [mfs_pkg::DELAY_W-1:0] delay_reg;
    logic [mfs_pkg::RATE_W-1:0]  rate_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= '0;
            rate_reg  <= mfs_pkg::RATE_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                mfs_pkg::REG_DELAY_IDX: delay_reg <= pwdata[mfs_pkg::DELAY_W-1:0];
                mfs_pkg::REG_RATE_IDX:  rate_reg  <= pwdata[mfs_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mfs_pkg::REG_DELAY_IDX: prdata = 32'(delay_reg);
            mfs_pkg::REG_RATE_IDX:  prdata = 32'(rate_reg);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shift in frames, recomputed after every register write
    // ------------------------------------------------------------------
    logic [mfs_pkg::SHIFT_W-1:0] shift;
    logic                        shift_valid;

    mfs_shift_calc u_shift (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (cfg_wr),
        .delay_i (delay_reg),
        .rate_i  (rate_reg),
        .shift_o (shift),
        .valid_o (shift_valid)
    );

    // ------------------------------------------------------------------
    // Front end: parsing, at most one command per input transfer
    // ------------------------------------------------------------------
    logic                  push;
    logic                  fifo_full;
    mfs_pkg::cmd_head_t    wr_head;
    logic [VALUE_BITS-1:0] wr_value;

    mfs_front #(
        .VALUE_BITS     (VALUE_BITS),
        .MAX_OUT_DIGITS (MAX_OUT_DIGITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_char (s_in_char),
        .s_in_last (s_in_last),
        .full_i    (fifo_full),
        .push_o    (push),
        .head_o    (wr_head),
        .value_o   (wr_value)
    );

    // ------------------------------------------------------------------
    // Command queue
    // ------------------------------------------------------------------
    logic [FIFO_W-1:0]     rd_data;
    logic                  cmd_valid;
    logic                  pop;
    mfs_pkg::cmd_head_t    rd_head;
    logic [VALUE_BITS-1:0] rd_value;

    mfs_cmd_fifo #(
        .WIDTH (FIFO_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (push),
        .wr_data_i   ({wr_head, wr_value}),
        .pop_i       (pop),
        .rd_data_o   (rd_data),
        .not_empty_o (cmd_valid),
        .full_o      (fifo_full)
    );

    assign rd_head  = mfs_pkg::cmd_head_t'(rd_data[FIFO_W-1 -: mfs_pkg::CMD_HEAD_W]);
    assign rd_value = rd_data[VALUE_BITS-1:0];

    // ------------------------------------------------------------------
    // Back end: byte expansion into the output register
    // ------------------------------------------------------------------
    mfs_back #(
        .VALUE_BITS     (VALUE_BITS),
        .MAX_OUT_DIGITS (MAX_OUT_DIGITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid_i   (cmd_valid),
        .pop_o         (pop),
        .head_i        (rd_head),
        .value_i       (rd_value),
        .shift_i       (shift),
        .shift_valid_i (shift_valid),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_run_end     (m_run_end),
        .m_stream_end  (m_stream_end)
    );

endmodule

>>> sim/tb_microdvd_frame_shift_unit.sv
// Self-checking bench for the MicroDVD frame shift unit: byte-level predictor and scoreboard,
// random subtitle streams, APB register writes and randomly stalling output side.
// Depends on mfs_pkg and microdvd_frame_shift_unit from rtl/core.
`timescale 1ns / 1ps

// Parse modes of the predictor
typedef enum logic [1:0] {
    PM_COPY,
    PM_BRACE,
    PM_FRAME
} parse_mode_e;

// Saturation limit with the default parameters: min(2^VALUE_BITS - 1, ten nines)
localparam logic [63:0] BIN_CAP   = (64'd1 << mfs_pkg::VALUE_BITS_DEF) - 64'd1;
localparam logic [63:0] DEC_CAP   = 64'd9_999_999_999;
localparam logic [63:0] FIELD_CAP = (BIN_CAP < DEC_CAP) ? BIN_CAP : DEC_CAP;

class subtitle_shift_board;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       stream_end;
    } out_byte_t;

    out_byte_t   owed[$];     // expected output bytes, oldest first
    out_byte_t   fresh[$];    // bytes caused by the current input
    parse_mode_e mode;
    logic [63:0] field_val;
    logic        digits_done;
    logic        nl_last;
    logic [63:0] delay_ms;
    logic [63:0] frame_rate;
    int          mismatches;
    int          bytes_in;
    int          bytes_out;
    int          fields;
    int          streams;

    function new();
        mode        = PM_COPY;
        field_val   = '0;
        digits_done = 1'b0;
        nl_last     = 1'b0;
        delay_ms    = '0;
        frame_rate  = 64'(mfs_pkg::RATE_RESET);
        mismatches  = 0;
        bytes_in    = 0;
        bytes_out   = 0;
        fields      = 0;
        streams     = 0;
    endfunction

    function void set_register(input logic idx, input logic [31:0] data);
        if (idx == mfs_pkg::REG_DELAY_IDX) begin
            delay_ms = 64'(data[mfs_pkg::DELAY_W-1:0]);
        end else begin
            frame_rate = 64'(data[mfs_pkg::RATE_W-1:0]);
        end
    endfunction

    function void emit(input logic [7:0] c);
        out_byte_t b;
        b.ch         = c;
        b.run_end    = 1'b0;
        b.stream_end = 1'b0;
        fresh.push_back(b);
        nl_last = (c == mfs_pkg::CHAR_LF);
    endfunction

    // '{', shifted value in decimal, '}'
    function void close_field();
        logic [63:0] shift;
        logic [63:0] sum;
        string       digs;
        shift = (delay_ms * frame_rate) / 64'd1000;
        sum   = (shift > FIELD_CAP - field_val) ? FIELD_CAP : field_val + shift;
        digs  = $sformatf("%0d", sum);
        emit(mfs_pkg::CHAR_LBRACE);
        for (int i = 0; i < digs.len(); i++) begin
            emit(digs[i]);
        end
        emit(mfs_pkg::CHAR_RBRACE);
        mode        = PM_COPY;
        field_val   = '0;
        digits_done = 1'b0;
        fields++;
    endfunction

    function void copy_in(input logic [7:0] c);
        if (c == mfs_pkg::CHAR_LBRACE) begin
            mode = PM_BRACE;
        end else begin
            emit(c);
        end
    endfunction

    // Note one accepted input transfer and queue the bytes it must produce
    function void take_byte(input logic [7:0] c, input logic last);
        logic        numeral;
        logic [63:0] v;
        out_byte_t   b;
        numeral = (c >= mfs_pkg::CHAR_ZERO) && (c <= mfs_pkg::CHAR_NINE);
        fresh.delete();
        bytes_in++;
        case (mode)
            PM_BRACE: begin
                if (numeral) begin
                    mode        = PM_FRAME;
                    field_val   = 64'(c - mfs_pkg::CHAR_ZERO);
                    digits_done = 1'b0;
                end else begin
                    emit(mfs_pkg::CHAR_LBRACE);
                    mode = PM_COPY;
                    copy_in(c);
                end
            end
            PM_FRAME: begin
                if (c == mfs_pkg::CHAR_RBRACE) begin
                    close_field();
                end else if (!digits_done && numeral) begin
                    v         = field_val * 64'd10 + 64'(c - mfs_pkg::CHAR_ZERO);
                    field_val = (v > FIELD_CAP) ? FIELD_CAP : v;
                end else begin
                    digits_done = 1'b1;
                end
            end
            default: begin
                copy_in(c);
            end
        endcase
        if (last) begin
            if (mode == PM_BRACE) begin
                emit(mfs_pkg::CHAR_LBRACE);
            end else if (mode == PM_FRAME) begin
                close_field();
            end
            if (!nl_last) begin
                emit(mfs_pkg::CHAR_LF);
            end
            b = fresh.pop_back();
            b.stream_end = 1'b1;
            fresh.push_back(b);
            mode        = PM_COPY;
            field_val   = '0;
            digits_done = 1'b0;
            nl_last     = 1'b0;
            streams++;
        end
        if (fresh.size() > 0) begin
            b = fresh.pop_back();
            b.run_end = 1'b1;
            fresh.push_back(b);
        end
        foreach (fresh[i]) begin
            owed.push_back(fresh[i]);
        end
    endfunction

    task report(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // Compare one accepted output transfer with the oldest owed byte
    task check_byte(input logic [7:0] ch, input logic run_end, input logic stream_end);
        out_byte_t want;
        bytes_out++;
        if (owed.size() == 0) begin
            report($sformatf("output byte 0x%02h arrived with nothing owed", ch));
        end else begin
            want = owed.pop_front();
            if (ch !== want.ch) begin
                report($sformatf("out_char 0x%02h, want 0x%02h", ch, want.ch));
            end
            if (run_end !== want.run_end) begin
                report($sformatf("run_end %b, want %b (byte 0x%02h)", run_end, want.run_end,
                                 want.ch));
            end
            if (stream_end !== want.stream_end) begin
                report($sformatf("stream_end %b, want %b (byte 0x%02h)", stream_end,
                                 want.stream_end, want.ch));
            end
        end
    endtask

endclass

module tb_microdvd_frame_shift_unit;

    // Pause before a register write: covers a field conversion plus its longest byte run,
    // so a field still in flight has drained.
    localparam int SETTLE_CYCLES  = 120;
    // Cycles without any transfer before the run is declared hung; the slowest correct gap
    // (shift recompute, conversion, long stall, settle pause) stays well under this.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BYTES    = 80;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_LONG_STALLS
    } rx_style_e;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic [7:0]  s_in_char    = 8'h00;
    logic        s_in_last    = 1'b0;
    logic        m_ready      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = 3'b000;
    logic [31:0] pwdata       = 32'h0;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_out_char;
    logic        m_run_end;
    logic        m_stream_end;
    logic [31:0] prdata;
    logic        pready;

    subtitle_shift_board board = new();

    logic [8:0]  text_q[$];       // {last, byte} of the stream being sent
    int          burst_left   = 0;
    int          quiet_cycles = 0;
    int          rx_cycle     = 0;
    int          rx_hold      = 0;
    rx_style_e   rx_style     = RX_ALWAYS;
    int          settings     = 1;

    microdvd_frame_shift_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_char    (s_in_char),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_run_end    (m_run_end),
        .m_stream_end (m_stream_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Monitor: sample both channels at the edge; inputs are noted before outputs are checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.take_byte(s_in_char, s_in_last);
            end
            if (m_valid && m_ready) begin
                board.check_byte(m_out_char, m_run_end, m_stream_end);
            end
        end
    end

    // Watchdog: any transfer or register access counts as progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired: no transfer for %0d cycles, %0d bytes still owed",
                     WATCHDOG_LIMIT, board.owed.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver back-pressure: styles drawn at random in turn, always-ready among them
    always @(posedge aclk) begin
        if (rx_cycle % 48 == 0) begin
            rx_style = rx_style_e'($urandom_range(0, 3));
        end
        rx_cycle++;
        case (rx_style)
            RX_ALWAYS: begin
                m_ready <= 1'b1;
            end
            RX_COIN: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            RX_ONE_IN_FOUR: begin
                m_ready <= (rx_cycle % 4 == 0);
            end
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    rx_hold = $urandom_range(0, 12);
                end
            end
        endcase
    end

    // One input transfer. Gaps come before valid is raised, so valid is never
    // dropped and raised in the same step.
    task automatic send_byte(input logic [7:0] ch, input logic last);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30)
                                                      : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_in_char <= ch;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text();
        foreach (text_q[i]) begin
            send_byte(text_q[i][7:0], i == text_q.size() - 1);
        end
    endtask

    task automatic put(input logic [7:0] ch);
        text_q.push_back({1'b0, ch});
    endtask

    // "{digits}", sometimes with a letter and a stray digit after the leading digits
    task automatic add_field(input bit closed);
        int ndig;
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 5);
        put(mfs_pkg::CHAR_LBRACE);
        repeat (ndig) put(8'($urandom_range(mfs_pkg::CHAR_ZERO, mfs_pkg::CHAR_NINE)));
        if ($urandom_range(0, 5) == 0) begin
            put(8'($urandom_range(8'h61, 8'h7A)));
            put(8'($urandom_range(mfs_pkg::CHAR_ZERO, mfs_pkg::CHAR_NINE)));
        end
        if (closed) begin
            put(mfs_pkg::CHAR_RBRACE);
        end
    endtask

    // Mostly well-formed subtitle lines, with noise, stray braces and open endings
    task automatic build_stream();
        int         segs;
        int         kind;
        bit         done;
        logic [7:0] c;
        text_q.delete();
        segs = $urandom_range(1, 5);
        done = 1'b0;
        for (int s = 0; s < segs && !done; s++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                // typical line: {start}{end}text, usually newline-terminated
                add_field(1'b1);
                add_field(1'b1);
                repeat ($urandom_range(1, 8)) put(8'($urandom_range(8'h61, 8'h7A)));
                if ($urandom_range(0, 3) != 0) begin
                    put(mfs_pkg::CHAR_LF);
                end
            end else if (kind == 6) begin
                repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
            end else if (kind == 7) begin
                // brace not opening a field
                do c = 8'($urandom_range(0, 255));
                while (c >= mfs_pkg::CHAR_ZERO && c <= mfs_pkg::CHAR_NINE);
                put(mfs_pkg::CHAR_LBRACE);
                put(c);
            end else if (kind == 8) begin
                // double brace in front of a field
                put(mfs_pkg::CHAR_LBRACE);
                add_field(1'b1);
            end else begin
                // stream closes on a pending brace or an open field
                if ($urandom_range(0, 1) == 1) begin
                    put(mfs_pkg::CHAR_LBRACE);
                end else begin
                    add_field(1'b0);
                end
                done = 1'b1;
            end
        end
    endtask

    task automatic run_phase(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            build_stream();
            send_text();
            sent += text_q.size();
        end
    endtask

    // Drop valid, let every owed byte arrive and give any field still converting time to drain
    task automatic settle();
        s_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup, then access until pready; register takes effect at that edge
    task automatic write_reg(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(idx, data);
    endtask

    task automatic new_setting(input logic [31:0] delay, input logic [31:0] rate);
        write_reg(mfs_pkg::REG_DELAY_IDX, delay);
        write_reg(mfs_pkg::REG_RATE_IDX, rate);
        settings++;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed streams under reset settings (no shift).
        // Byte extremes, double brace, digits after a letter inside a field,
        // brace before a non-digit, value saturation, newline already at the end.
        text_q.delete();
        put(8'h00);
        put(8'hFF);
        put(mfs_pkg::CHAR_LBRACE);
        put(mfs_pkg::CHAR_LBRACE);
        put("7");
        put("x");
        put("3");
        put(mfs_pkg::CHAR_RBRACE);
        put(mfs_pkg::CHAR_LBRACE);
        put(mfs_pkg::CHAR_RBRACE);
        put(mfs_pkg::CHAR_LBRACE);
        repeat (10) put("9");
        put(mfs_pkg::CHAR_RBRACE);
        put(mfs_pkg::CHAR_LF);
        send_text();
        // stream that ends on a pending brace
        text_q.delete();
        put(mfs_pkg::CHAR_LBRACE);
        send_text();
        // stream that ends inside a field
        text_q.delete();
        put(mfs_pkg::CHAR_LBRACE);
        put("5");
        send_text();

        run_phase(PHASE_BYTES);
        settle();

        // Everything set, bits above the register widths included: largest shift
        new_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(PHASE_BYTES);
        settle();

        // One day at 1000 fps
        new_setting(32'd86_400_000, 32'd1000);
        run_phase(PHASE_BYTES);
        settle();

        // Zero rate: any delay gives no shift
        new_setting(32'($urandom_range(0, 86_400_000)), 32'd0);
        run_phase(PHASE_BYTES);
        settle();

        // Smallest non-zero shift
        new_setting(32'd1000, 32'd1);
        run_phase(PHASE_BYTES);
        settle();

        new_setting(32'($urandom_range(0, 86_400_000)), 32'($urandom_range(1, 1000)));
        run_phase(PHASE_BYTES);
        settle();

        $display("Run covered %0d input bytes and %0d output bytes: %0d frame fields, %0d streams",
                 board.bytes_in, board.bytes_out, board.fields, board.streams);
        $display("Register settings used: %0d, from no shift up to the widest delay and rate",
                 settings);
        if (board.mismatches == 0 && board.owed.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
